// ----- rtl/plcr_pkg.sv -----
// ============================================================================
// plcr_pkg: shared constants for the point light cutoff radius core
// Widths, register indexes and reset values used by the pipeline.
// ============================================================================
package plcr_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUAD_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SCALE   = 1'd1;

  localparam logic [THR_W-1:0]   QUAD_THRESHOLD_RST = 16'd7;
  localparam logic [SCALE_W-1:0] CUTOFF_SCALE_RST   = 8'd32;

  localparam logic [COEF_W-1:0] RADIUS_MAX = 24'hFFFFFF;

  // Work word width for the square root cells: remainder and partial root.
  // Held wide enough for the discriminant (below 2^53 with out-of-range
  // levels).
  localparam int unsigned DISC_W = 54;
  localparam int unsigned ROOT_W = DISC_W / 2;

endpackage

// ----- rtl/plcr_if.sv -----
// ============================================================================
// plcr_if: valid/ready channel carrying one payload word
// Source drives valid and payload, sink drives ready.
// ============================================================================
interface plcr_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/plcr_sqrt_cell.sv -----
// ============================================================================
// plcr_sqrt_cell: one digit of a restoring square root
// One root bit per cycle while enabled; hands the remainder to its neighbor.
// ============================================================================
module plcr_sqrt_cell #(
  parameter int unsigned W     = 52,
  parameter int unsigned SHIFT = 50,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      in_rem,
  input  logic [W-1:0]      in_root,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_rem,
  output logic [W-1:0]      out_root,
  output logic [SIDE_W-1:0] out_side
);
  logic [W-1:0] bitv;
  logic [W-1:0] trial;
  logic [W-1:0] rem_next;
  logic [W-1:0] root_next;

  assign bitv  = W'(1) << SHIFT;
  assign trial = in_root + bitv;

  always_comb begin
    if (in_rem >= trial) begin
      rem_next  = in_rem - trial;
      root_next = (in_root >> 1) + bitv;
    end else begin
      rem_next  = in_rem;
      root_next = in_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_root <= root_next;
      out_side <= in_side;
    end
  end
endmodule

// ----- rtl/plcr_div_cell.sv -----
// ============================================================================
// plcr_div_cell: one bit of a restoring divider
// One quotient bit per cycle while enabled; passes the partial remainder on.
// ============================================================================
module plcr_div_cell #(
  parameter int unsigned NW     = 50,
  parameter int unsigned DW     = 26,
  parameter int unsigned QW     = 25,
  parameter int unsigned BITPOS = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW:0]       in_rem,
  input  logic [DW-1:0]     in_den,
  input  logic [QW-1:0]     in_quo,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NW-1:0]     out_num,
  output logic [DW:0]       out_rem,
  output logic [DW-1:0]     out_den,
  output logic [QW-1:0]     out_quo,
  output logic [SIDE_W-1:0] out_side
);
  logic [DW+1:0] shifted;
  logic          fits;
  logic [DW:0]   rem_next;
  logic [QW-1:0] quo_next;

  // Remainder stays below the divisor, so shifted fits in DW+2 bits.
  assign shifted = {in_rem, in_num[BITPOS]};
  assign fits    = shifted >= {2'b00, in_den};

  always_comb begin
    quo_next = in_quo;
    if (fits) begin
      rem_next = (DW+1)'(shifted - {2'b00, in_den});
      if (BITPOS < QW) begin
        quo_next[BITPOS % QW] = 1'b1;
      end
    end else begin
      rem_next = shifted[DW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num  <= in_num;
      out_rem  <= rem_next;
      out_den  <= in_den;
      out_quo  <= quo_next;
      out_side <= in_side;
    end
  end
endmodule

// ----- rtl/point_light_cutoff_radius_core.sv -----
// ============================================================================
// point_light_cutoff_radius_core: one cutoff radius per cycle unless stalled
// Brightness, discriminant, square root cells and divider cells in one row.
// ============================================================================
// Usage: lights enter on in_ch (valid/ready), one radius word leaves on
// out_ch for every light, in order. Both channels are valid/ready: a word
// moves at a clock edge where valid and ready are both high.
// Throughput: one light per cycle while out_ch is not stalled. The pipeline
// is a row of cells: four front stages (max, brightness product, k,
// discriminant), 27 square root cells, one numerator stage, 43 divider
// cells (one per numerator bit) and a final saturation stage feeding a
// two-entry skid buffer on the output.
// When the receiver stalls, the whole row holds once the skid buffer is
// full; in_ch.ready drops in the same cycle, so nothing is lost.
// Reset (rst, synchronous): clears all valid bits and loads the registers
// with quad_threshold = 7 and cutoff_scale = 32. Configuration is written
// through cfg_wr_en / cfg_index / cfg_data; unknown indexes are ignored.
// ============================================================================
module point_light_cutoff_radius_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [plcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plcr_pkg::CFG_W-1:0]     cfg_data,
  plcr_if.sink                           in_ch,
  plcr_if.source                         out_ch
);
  import plcr_pkg::*;

  // k and the root reach 2^26, the discriminant (Q.2F) stays below 2^53;
  // numerator shifted by F.
  localparam int unsigned NUM_W  = COEF_W + 3;
  localparam int unsigned DIVN_W = NUM_W + FRAC_BITS;
  localparam int unsigned DEN_W  = COEF_W + 1;
  localparam int unsigned QUO_W  = COEF_W + 1;
  localparam int unsigned NSQ    = ROOT_W;
  localparam int unsigned NDIV   = DIVN_W;

  typedef struct packed {
    logic              lin_mode;
    logic              zero_den;
    logic              no_num;
    logic [COEF_W-1:0] lin;
    logic [COEF_W-1:0] quad;
    logic [NUM_W-1:0]  knum;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  logic [THR_W-1:0]   quad_threshold;
  logic [SCALE_W-1:0] cutoff_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_threshold <= QUAD_THRESHOLD_RST;
      cutoff_scale   <= CUTOFF_SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_QUAD_THRESHOLD: quad_threshold <= cfg_data[THR_W-1:0];
        REG_CUTOFF_SCALE:   cutoff_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Skid buffer at the output decides whether the row advances.
  logic en;
  logic fin_valid;
  logic [COEF_W-1:0] fin_rad;
  logic fin_sat;
  logic [1:0] sk_cnt;
  logic [COEF_W:0] sk_data [2];

  assign en = (sk_cnt != 2'd2);
  assign in_ch.ready = en;

  // ---- front stages ----
  logic              s1_v, s2_v, s3_v, s4_v;
  logic [LEVEL_W-1:0] s1_maxc, s1_int;
  logic [COEF_W-1:0] s1_c, s1_l, s1_q;
  logic [SCALE_W-1:0] s1_scale;
  logic              s1_lm;
  logic [2*LEVEL_W-1:0] s2_mi;
  logic [COEF_W-1:0] s2_c, s2_l, s2_q;
  logic [SCALE_W-1:0] s2_scale;
  logic              s2_lm;
  logic [NUM_W-1:0]  s3_k;
  logic [COEF_W-1:0] s3_c, s3_l, s3_q;
  logic              s3_lm;
  logic [DISC_W-1:0] s4_disc;
  logic              s4_neg;
  side_t             s4_side;

  logic [LEVEL_W-1:0] maxc;
  always_comb begin
    maxc = in_ch.payload.red_level;
    if (in_ch.payload.green_level > maxc) maxc = in_ch.payload.green_level;
    if (in_ch.payload.blue_level > maxc) maxc = in_ch.payload.blue_level;
  end

  logic [2*LEVEL_W+SCALE_W-1:0] kfull;
  assign kfull = {{SCALE_W{1'b0}}, s2_mi} * {{(2*LEVEL_W){1'b0}}, s2_scale};

  // Stage 4 terms
  logic [2*COEF_W-1:0] lsq;
  logic [COEF_W+NUM_W+1:0] tq;
  logic              k_ge;
  logic [NUM_W-1:0]  kdiff;
  logic [NUM_W-1:0]  s3_cw;
  assign s3_cw = {{(NUM_W-COEF_W){1'b0}}, s3_c};
  assign k_ge  = s3_k >= s3_cw;
  assign kdiff = k_ge ? (s3_k - s3_cw) : (s3_cw - s3_k);
  assign lsq   = {{COEF_W{1'b0}}, s3_l} * {{COEF_W{1'b0}}, s3_l};
  assign tq    = ({{(NUM_W+2){1'b0}}, s3_q} * {{(COEF_W+2){1'b0}}, kdiff}) << 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_ch.valid; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_maxc  <= maxc;
      s1_int   <= in_ch.payload.light_intensity;
      s1_c     <= in_ch.payload.const_atten;
      s1_l     <= in_ch.payload.lin_atten;
      s1_q     <= in_ch.payload.quad_atten;
      s1_scale <= cutoff_scale;
      s1_lm    <= in_ch.payload.quad_atten < {{(COEF_W-THR_W){1'b0}}, quad_threshold};

      s2_mi    <= {{LEVEL_W{1'b0}}, s1_maxc} * {{LEVEL_W{1'b0}}, s1_int};
      s2_c <= s1_c; s2_l <= s1_l; s2_q <= s1_q; s2_scale <= s1_scale; s2_lm <= s1_lm;

      s3_k <= NUM_W'(kfull >> FRAC_BITS);
      s3_c <= s2_c; s3_l <= s2_l; s3_q <= s2_q; s3_lm <= s2_lm;

      if (k_ge) begin
        s4_disc <= DISC_W'(lsq) + DISC_W'(tq);
        s4_neg  <= 1'b0;
      end else begin
        s4_disc <= DISC_W'(lsq) - DISC_W'(tq);
        s4_neg  <= {{(COEF_W+NUM_W+2-2*COEF_W){1'b0}}, lsq} < tq;
      end
      s4_side.lin_mode <= s3_lm;
      s4_side.zero_den <= s3_lm ? (s3_l == '0) : (s3_q == '0);
      s4_side.no_num   <= s3_lm ? !(s3_k > s3_cw) : 1'b0;
      s4_side.lin      <= s3_l;
      s4_side.quad     <= s3_q;
      s4_side.knum     <= kdiff;
    end
  end

  // ---- square root cells ----
  logic              sq_v    [NSQ+1];
  logic [DISC_W-1:0] sq_rem  [NSQ+1];
  logic [DISC_W-1:0] sq_root [NSQ+1];
  side_t             sq_side [NSQ+1];

  assign sq_v[0]    = s4_v;
  assign sq_rem[0]  = s4_neg ? '0 : s4_disc;
  assign sq_root[0] = '0;
  always_comb begin
    sq_side[0] = s4_side;
    if (s4_neg) sq_side[0].no_num = 1'b1;
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    plcr_sqrt_cell #(.W(DISC_W), .SHIFT(DISC_W - 2 - 2*i), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sq_v[i]), .in_rem(sq_rem[i]), .in_root(sq_root[i]),
      .in_side(sq_side[i]),
      .out_valid(sq_v[i+1]), .out_rem(sq_rem[i+1]), .out_root(sq_root[i+1]),
      .out_side(sq_side[i+1])
    );
  end

  // ---- numerator stage ----
  logic              n_v;
  logic [NUM_W-1:0]  n_num;
  logic [DEN_W-1:0]  n_den;
  side_t             n_side;
  side_t             sq_last;
  logic [ROOT_W-1:0] s_root;
  assign sq_last = sq_side[NSQ];
  assign s_root  = sq_root[NSQ][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (en) begin
      n_v <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_side <= sq_last;
      if (sq_last.lin_mode) begin
        n_num <= sq_last.knum;
        n_den <= {1'b0, sq_last.lin};
      end else begin
        n_num <= (s_root > {{(ROOT_W-COEF_W){1'b0}}, sq_last.lin})
                 ? NUM_W'(s_root - {{(ROOT_W-COEF_W){1'b0}}, sq_last.lin}) : '0;
        n_den <= {sq_last.quad, 1'b0};
      end
    end
  end

  // ---- divider cells ----
  logic              dv_v    [NDIV+1];
  logic [DIVN_W-1:0] dv_num  [NDIV+1];
  logic [DEN_W:0]    dv_rem  [NDIV+1];
  logic [DEN_W-1:0]  dv_den  [NDIV+1];
  logic [QUO_W-1:0]  dv_quo  [NDIV+1];
  logic [1:0]        dv_side [NDIV+1];
  logic [QUO_W-1:0]  dv_hi   [NDIV+1];

  assign dv_v[0]    = n_v;
  assign dv_num[0]  = {n_num, {FRAC_BITS{1'b0}}};
  assign dv_rem[0]  = '0;
  assign dv_den[0]  = n_den;
  assign dv_quo[0]  = '0;
  assign dv_hi[0]   = '0;
  // side: [1] zero divisor, [0] numerator is zero
  assign dv_side[0] = {n_side.zero_den, (n_side.no_num || n_num == '0)};

  // High quotient bits (from bit QUO_W up) collapse into an overflow flag,
  // kept in dv_hi[.][0].
  for (genvar j = 0; j < NDIV; j++) begin : g_dv
    localparam int unsigned BP = NDIV - 1 - j;
    logic [DEN_W:0]   rem_o;
    logic [QUO_W-1:0] quo_o;
    logic             v_o;
    logic [DIVN_W-1:0] num_o;
    logic [DEN_W-1:0] den_o;
    logic [1:0]       side_o;
    plcr_div_cell #(.NW(DIVN_W), .DW(DEN_W), .QW(QUO_W), .BITPOS(BP), .SIDE_W(2)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv_v[j]), .in_num(dv_num[j]), .in_rem(dv_rem[j]),
      .in_den(dv_den[j]), .in_quo(dv_quo[j]), .in_side(dv_side[j]),
      .out_valid(v_o), .out_num(num_o), .out_rem(rem_o),
      .out_den(den_o), .out_quo(quo_o), .out_side(side_o)
    );
    assign dv_v[j+1] = v_o; assign dv_num[j+1] = num_o; assign dv_rem[j+1] = rem_o;
    assign dv_den[j+1] = den_o; assign dv_quo[j+1] = quo_o; assign dv_side[j+1] = side_o;

    logic hi_r;
    logic [DEN_W+1:0] sh;
    assign sh = {dv_rem[j], dv_num[j][BP]};
    always_ff @(posedge clk) begin
      if (en) begin
        hi_r <= dv_hi[j][0] || (BP >= QUO_W && sh >= {2'b00, dv_den[j]});
      end
    end
    assign dv_hi[j+1] = {{(QUO_W-1){1'b0}}, hi_r};
  end

  // ---- saturation stage ----
  logic [QUO_W-1:0] qf;
  logic [1:0]       sf;
  logic             ovf;
  assign qf  = dv_quo[NDIV];
  assign sf  = dv_side[NDIV];
  assign ovf = dv_hi[NDIV][0] || qf[QUO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= dv_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sf[1]) begin
        fin_sat <= 1'b1;
        fin_rad <= sf[0] ? '0 : RADIUS_MAX;
      end else if (sf[0]) begin
        fin_sat <= 1'b0;
        fin_rad <= '0;
      end else if (ovf) begin
        fin_sat <= 1'b1;
        fin_rad <= RADIUS_MAX;
      end else begin
        fin_sat <= 1'b0;
        fin_rad <= qf[COEF_W-1:0];
      end
    end
  end

  // ---- output skid buffer (two entries) ----
  logic push, pop;
  assign push = fin_valid && en;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_cnt <= 2'd0;
    end else begin
      sk_cnt <= sk_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sk_data[0] <= (sk_cnt == 2'd2) ? sk_data[1] : {fin_sat, fin_rad};
    end else if (push && sk_cnt == 2'd0) begin
      sk_data[0] <= {fin_sat, fin_rad};
    end
    if (push && ((sk_cnt == 2'd1 && !pop) || (sk_cnt == 2'd2 && pop))) begin
      sk_data[1] <= {fin_sat, fin_rad};
    end
  end

  assign out_ch.valid = sk_cnt != 2'd0;
  assign out_ch.payload.light_radius     = sk_data[0][COEF_W-1:0];
  assign out_ch.payload.radius_saturated = sk_data[0][COEF_W];
endmodule

// ----- tb/point_light_cutoff_radius_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// point_light_cutoff_radius_core_tb: self-checking bench for the radius core
// Drives point lights through a valid/ready channel with random gaps and
// back-pressure. Every light is predicted in a scoreboard, and every radius
// word is checked in order. Covers several register settings, the extremes
// among them.
// ============================================================================
module point_light_cutoff_radius_core_tb;
  import plcr_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] light_intensity;
    logic [COEF_W-1:0]  const_atten;
    logic [COEF_W-1:0]  lin_atten;
    logic [COEF_W-1:0]  quad_atten;
  } light_t;

  typedef struct packed {
    logic [COEF_W-1:0] light_radius;
    logic              radius_saturated;
  } radius_t;

  localparam int unsigned FRAC = FRAC_BITS;

  class radius_scoreboard;
    radius_t     pending[$];
    logic [15:0] quad_threshold = QUAD_THRESHOLD_RST;
    logic [7:0]  cutoff_scale   = CUTOFF_SCALE_RST;
    int          mismatches = 0;
    int          lights = 0;
    int          checked = 0;
    int          sat_seen = 0;

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // numerator assumed positive unless divisor is zero
    function radius_t divide_sat(logic [63:0] num, logic [63:0] den);
      radius_t     r;
      logic [63:0] q;
      if (den == 0) begin
        r.radius_saturated = 1'b1;
        r.light_radius = (num > 0) ? RADIUS_MAX : '0;
      end else begin
        q = (num << FRAC) / den;
        r.radius_saturated = (q > RADIUS_MAX);
        r.light_radius = (q > RADIUS_MAX) ? RADIUS_MAX : q[COEF_W-1:0];
      end
      return r;
    endfunction

    function radius_t predict_radius(light_t l);
      radius_t     r;
      logic [63:0] maxc, k, c, lin, quad, lsq, disc, t, s, num;
      r = '0;
      maxc = 64'(l.red_level);
      if (l.green_level > maxc) maxc = 64'(l.green_level);
      if (l.blue_level > maxc) maxc = 64'(l.blue_level);
      k = (maxc * 64'(l.light_intensity) * 64'(cutoff_scale)) >> FRAC;
      c = 64'(l.const_atten);
      lin = 64'(l.lin_atten);
      quad = 64'(l.quad_atten);
      if (quad < quad_threshold) begin
        if (lin == 0 || k > c) r = divide_sat((k > c) ? k - c : 0, lin);
      end else begin
        lsq = lin * lin;
        if (k >= c) begin
          disc = lsq + 4 * quad * (k - c);
        end else begin
          t = 4 * quad * (c - k);
          if (lsq < t) return r;  // negative discriminant
          disc = lsq - t;
        end
        s = root_floor(disc);
        num = (s > lin) ? s - lin : 0;
        if (quad == 0 || num > 0) r = divide_sat(num, 2 * quad);
      end
      return r;
    endfunction

    function void note_light(light_t l);
      pending.push_back(predict_radius(l));
      lights++;
    endfunction

    function void check_radius(radius_t got);
      radius_t want;
      checked++;
      if (got.radius_saturated) sat_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: radius %h sat %b",
                                       got.light_radius, got.radius_saturated);
        return;
      end
      want = pending.pop_front();
      if (got.light_radius !== want.light_radius ||
          got.radius_saturated !== want.radius_saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: expected radius %h sat %b, got radius %h sat %b",
                   checked, want.light_radius, want.radius_saturated,
                   got.light_radius, got.radius_saturated);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  plcr_if #(.payload_t(light_t))  in_ch ();
  plcr_if #(.payload_t(radius_t)) out_ch ();

  point_light_cutoff_radius_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  radius_scoreboard radius_sb = new();
  bit no_idle = 1'b0;
  bit hold_done = 1'b0;

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  function int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // receiver: random stalls plus one long hold-off once the row is busy
  always begin
    @(negedge clk);
    if (!hold_done && radius_sb.checked >= 60) begin
      int n;
      hold_done = 1'b1;
      out_ch.ready = 1'b0;
      for (n = 0; n < 300; n++) @(negedge clk);
    end
    out_ch.ready = (gap_len() == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) radius_sb.check_radius(out_ch.payload);
  end

  task automatic send_light(light_t l);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload = l;
    do @(posedge clk); while (!in_ch.ready);
    radius_sb.note_light(l);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_ch.valid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_QUAD_THRESHOLD) radius_sb.quad_threshold = val[15:0];
    else radius_sb.cutoff_scale = val[7:0];
  endtask

  // block must be drained before a register moves
  task automatic drain();
    in_ch.valid = 1'b0;
    while (radius_sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function logic [LEVEL_W-1:0] rand_level();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 17'd65536;
    if (p == 1) return LEVEL_W'($urandom_range(0, 131071));
    return LEVEL_W'($urandom_range(0, 65536));
  endfunction

  function logic [COEF_W-1:0] rand_coef();
    int sh;
    sh = $urandom_range(0, 24);
    if (sh == 0) return '0;
    return COEF_W'($urandom & ((32'd1 << sh) - 1));
  endfunction

  function light_t rand_light();
    light_t l;
    l.red_level = rand_level();
    l.green_level = rand_level();
    l.blue_level = rand_level();
    l.light_intensity = rand_level();
    l.const_atten = rand_coef();
    l.lin_atten = rand_coef();
    l.quad_atten = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom_range(0, 10)) : rand_coef();
    return l;
  endfunction

  function light_t mk(int lvl, int inten, int c, int lin, int quad);
    light_t l;
    l.red_level = LEVEL_W'(lvl);
    l.green_level = LEVEL_W'(lvl / 2);
    l.blue_level = LEVEL_W'(lvl / 3);
    l.light_intensity = LEVEL_W'(inten);
    l.const_atten = COEF_W'(c);
    l.lin_atten = COEF_W'(lin);
    l.quad_atten = COEF_W'(quad);
    return l;
  endfunction

  task automatic random_lights(int n);
    repeat (n) send_light(rand_light());
  endtask

  initial begin
    light_t l;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings
    send_light('0);
    send_light(mk(65536, 65536, 0, 0, 0));             // zero linear, positive num
    send_light(mk(65536, 65536, 24'hFFFFFF, 0, 0));    // zero linear, k below const
    send_light(mk(65536, 65536, 0, 1, 0));             // overflow
    send_light(mk(65536, 65536, 65536, 65536, 3));     // linear formula
    send_light(mk(1000, 1000, 24'hFFFFFF, 10, 24'hFFFFFF)); // negative discriminant
    send_light(mk(65536, 65536, 0, 65536, 65536));     // quadratic root
    send_light(mk(65536, 65536, 0, 24'hFFFFFF, 24'hFFFFFF));
    send_light(mk(65536, 65536, 65536, 1, 7));         // quad at threshold
    send_light(mk(65536, 65536, 2097152, 100, 8));     // k equals const
    send_light(mk(131071, 131071, 0, 1, 24'hFFFFFF));  // out-of-range levels
    l = mk(0, 131071, 5, 5, 5);
    l.blue_level = 131071;
    send_light(l);
    l.green_level = 131071; l.blue_level = 0;
    send_light(l);
    no_idle = 1'b1;
    random_lights(60);
    no_idle = 1'b0;
    random_lights(90);

    drain();
    write_reg(REG_QUAD_THRESHOLD, '0);
    write_reg(REG_CUTOFF_SCALE, CFG_W'(1));
    send_light(mk(65536, 65536, 0, 0, 0));             // quad zero with zero threshold
    send_light(mk(65536, 65536, 24'hFFFFFF, 5, 0));
    random_lights(80);

    drain();
    write_reg(REG_QUAD_THRESHOLD, 16'hFFFF);
    write_reg(REG_CUTOFF_SCALE, CFG_W'(255));
    send_light(mk(131071, 131071, 0, 1, 0));
    random_lights(80);

    drain();
    write_reg(REG_CUTOFF_SCALE, CFG_W'(0));            // k forced to zero
    random_lights(40);

    drain();
    write_reg(REG_QUAD_THRESHOLD, CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_CUTOFF_SCALE, CFG_W'($urandom_range(1, 255)));
    random_lights(90);

    in_ch.valid = 1'b0;
    while (radius_sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Run covered %0d lights over five register settings, %0d words checked,",
             radius_sb.lights, radius_sb.checked);
    $display("%0d of them saturated; one long receiver stall filled the pipeline.",
             radius_sb.sat_seen);
    if (radius_sb.mismatches == 0 && radius_sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", radius_sb.mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout, %0d words still pending", radius_sb.pending.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
